@@ rtl/park_pkg.sv @@
package park_pkg;

  localparam int DATA_W = 16;
  localparam int ROM_AW = 8;
  localparam int ROM_DEPTH = 1 << ROM_AW;

  // Operations carried in the user field
  localparam logic CMD_FWD = 1'b0;
  localparam logic CMD_INV = 1'b1;

  // Quadrant codes, taken from the two top bits of the offset angle index
  localparam logic [1:0] QUAD_0 = 2'b00;
  localparam logic [1:0] QUAD_1 = 2'b01;
  localparam logic [1:0] QUAD_2 = 2'b10;
  localparam logic [1:0] QUAD_3 = 2'b11;

  // Quarter-wave sine, Q15, peak 0x7FFE
  localparam logic [DATA_W-1:0] SINE_ROM [ROM_DEPTH] = '{
    16'h0000, 16'h00C9, 16'h0192, 16'h025B, 16'h0324, 16'h03ED, 16'h04B6, 16'h057F,
    16'h0648, 16'h0711, 16'h07D9, 16'h08A2, 16'h096A, 16'h0A33, 16'h0AFB, 16'h0BC4,
    16'h0C8C, 16'h0D54, 16'h0E1C, 16'h0EE3, 16'h0FAB, 16'h1072, 16'h113A, 16'h1201,
    16'h12C8, 16'h138F, 16'h1455, 16'h151C, 16'h15E2, 16'h16A8, 16'h176E, 16'h1833,
    16'h18F9, 16'h19BE, 16'h1A82, 16'h1B47, 16'h1C0B, 16'h1CCF, 16'h1D93, 16'h1E57,
    16'h1F1A, 16'h1FDD, 16'h209F, 16'h2161, 16'h2223, 16'h22E5, 16'h23A6, 16'h2467,
    16'h2528, 16'h25E8, 16'h26A8, 16'h2767, 16'h2826, 16'h28E5, 16'h29A3, 16'h2A61,
    16'h2B1F, 16'h2BDC, 16'h2C99, 16'h2D55, 16'h2E11, 16'h2ECC, 16'h2F87, 16'h3041,
    16'h30FB, 16'h31B5, 16'h326E, 16'h3326, 16'h33DF, 16'h3496, 16'h354D, 16'h3604,
    16'h36BA, 16'h376F, 16'h3824, 16'h38D9, 16'h398C, 16'h3A40, 16'h3AF2, 16'h3BA5,
    16'h3C56, 16'h3D07, 16'h3DB8, 16'h3E68, 16'h3F17, 16'h3FC5, 16'h4073, 16'h4121,
    16'h41CE, 16'h427A, 16'h4325, 16'h43D0, 16'h447A, 16'h4524, 16'h45CD, 16'h4675,
    16'h471C, 16'h47C3, 16'h4869, 16'h490F, 16'h49B4, 16'h4A58, 16'h4AFB, 16'h4B9D,
    16'h4C3F, 16'h4CE0, 16'h4D81, 16'h4E20, 16'h4EBF, 16'h4F5D, 16'h4FFB, 16'h5097,
    16'h5133, 16'h51CE, 16'h5268, 16'h5302, 16'h539B, 16'h5432, 16'h54C9, 16'h5560,
    16'h55F5, 16'h568A, 16'h571D, 16'h57B0, 16'h5842, 16'h58D3, 16'h5964, 16'h59F3,
    16'h5A82, 16'h5B0F, 16'h5B9C, 16'h5C28, 16'h5CB3, 16'h5D3E, 16'h5DC7, 16'h5E4F,
    16'h5ED7, 16'h5F5D, 16'h5FE3, 16'h6068, 16'h60EB, 16'h616E, 16'h61F0, 16'h6271,
    16'h62F1, 16'h6370, 16'h63EE, 16'h646C, 16'h64E8, 16'h6563, 16'h65DD, 16'h6656,
    16'h66CF, 16'h6746, 16'h67BC, 16'h6832, 16'h68A6, 16'h6919, 16'h698B, 16'h69FD,
    16'h6A6D, 16'h6ADC, 16'h6B4A, 16'h6BB7, 16'h6C23, 16'h6C8E, 16'h6CF8, 16'h6D61,
    16'h6DC9, 16'h6E30, 16'h6E96, 16'h6EFB, 16'h6F5E, 16'h6FC1, 16'h7022, 16'h7083,
    16'h70E2, 16'h7140, 16'h719D, 16'h71F9, 16'h7254, 16'h72AE, 16'h7307, 16'h735E,
    16'h73B5, 16'h740A, 16'h745F, 16'h74B2, 16'h7504, 16'h7555, 16'h75A5, 16'h75F3,
    16'h7641, 16'h768D, 16'h76D8, 16'h7722, 16'h776B, 16'h77B3, 16'h77FA, 16'h783F,
    16'h7884, 16'h78C7, 16'h7909, 16'h794A, 16'h7989, 16'h79C8, 16'h7A05, 16'h7A41,
    16'h7A7C, 16'h7AB6, 16'h7AEE, 16'h7B26, 16'h7B5C, 16'h7B91, 16'h7BC5, 16'h7BF8,
    16'h7C29, 16'h7C59, 16'h7C88, 16'h7CB6, 16'h7CE3, 16'h7D0E, 16'h7D39, 16'h7D62,
    16'h7D89, 16'h7DB0, 16'h7DD5, 16'h7DFA, 16'h7E1D, 16'h7E3E, 16'h7E5F, 16'h7E7E,
    16'h7E9C, 16'h7EB9, 16'h7ED5, 16'h7EEF, 16'h7F09, 16'h7F21, 16'h7F37, 16'h7F4D,
    16'h7F61, 16'h7F74, 16'h7F86, 16'h7F97, 16'h7FA6, 16'h7FB4, 16'h7FC1, 16'h7FCD,
    16'h7FD8, 16'h7FE1, 16'h7FE9, 16'h7FF0, 16'h7FF5, 16'h7FF9, 16'h7FFD, 16'h7FFE
  };

  // Operands held between the angle lookup and the rotation
  typedef struct packed {
    logic                     cmd;
    logic signed [DATA_W-1:0] sin;
    logic signed [DATA_W-1:0] cos;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
  } stage_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] first;
    logic signed [DATA_W-1:0] second;
  } result_t;

endpackage

@@ rtl/park_sincos.sv @@
module park_sincos
  import park_pkg::*;
(
  input  logic signed [DATA_W-1:0] theta,
  output logic signed [DATA_W-1:0] sin,
  output logic signed [DATA_W-1:0] cos
);

  logic [1:0]               quad;
  logic [ROM_AW-1:0]        addr;
  logic signed [DATA_W-1:0] direct;
  logic signed [DATA_W-1:0] mirror;

  // Offset by half a turn: flip the sign bit, then drop the six low bits
  assign quad   = {~theta[DATA_W-1], theta[DATA_W-2]};
  assign addr   = theta[DATA_W-3 -: ROM_AW];
  assign direct = SINE_ROM[addr];
  assign mirror = SINE_ROM[~addr];

  always_comb begin
    unique case (quad)
      QUAD_2: begin
        sin = direct;
        cos = mirror;
      end
      QUAD_3: begin
        sin = mirror;
        cos = -direct;
      end
      QUAD_0: begin
        sin = -direct;
        cos = -mirror;
      end
      QUAD_1: begin
        sin = -mirror;
        cos = direct;
      end
      default: begin
        sin = '0;
        cos = '0;
      end
    endcase
  end

endmodule

@@ rtl/park_rot.sv @@
module park_rot
  import park_pkg::*;
(
  input  stage_t  op,
  output result_t res
);

  localparam int PROD_W = 2 * DATA_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int FRAC   = DATA_W - 1;

  logic signed [PROD_W-1:0] xc;
  logic signed [PROD_W-1:0] ys;
  logic signed [PROD_W-1:0] yc;
  logic signed [PROD_W-1:0] xs;
  logic signed [SUM_W-1:0]  sum_first;
  logic signed [SUM_W-1:0]  sum_second;

  assign xc = op.x * op.cos;
  assign ys = op.y * op.sin;
  assign yc = op.y * op.cos;
  assign xs = op.x * op.sin;

  always_comb begin
    unique case (op.cmd)
      CMD_FWD: begin
        sum_first  = SUM_W'(xc) + SUM_W'(ys);
        sum_second = SUM_W'(yc) - SUM_W'(xs);
      end
      CMD_INV: begin
        sum_first  = SUM_W'(xc) - SUM_W'(ys);
        sum_second = SUM_W'(yc) + SUM_W'(xs);
      end
      default: begin
        sum_first  = '0;
        sum_second = '0;
      end
    endcase
  end

  // Shift right by the Q15 fraction and wrap to the output width
  assign res.first  = sum_first[FRAC +: DATA_W];
  assign res.second = sum_second[FRAC +: DATA_W];

endmodule

@@ rtl/park_transform_q15.sv @@
// Channel  | Dir | Bits | Contents
// s_axis   | in  | 48   | tdata: theta, in_first, in_second; tuser: cmd
// m_axis   | out | 32   | tdata: out_first, out_second
//
// Two register stages: the angle lookup feeds an operand register, the four
// 16x16 products and two adds feed the output register.
// One word is taken every cycle unless m_tready stalls the output; throughput is set by the single multiply stage.
// When m_tready is low, both stages fill and s_tready drops; each stage
// advances as soon as the one after it is empty or draining.
// Synchronous reset empties both stages; payload registers are not reset.
module park_transform_q15
  import park_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // theta[15:0], in_first[31:16], in_second[47:32]
  input  logic        s_tuser,   // cmd[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // out_first[15:0], out_second[31:16]
);

  logic                     st_valid;
  stage_t                   st;
  stage_t                   st_next;
  logic                     st_ready;
  logic                     out_valid;
  result_t                  out_data;
  result_t                  out_next;
  logic signed [DATA_W-1:0] sin;
  logic signed [DATA_W-1:0] cos;

  park_sincos u_sincos (
    .theta (s_tdata[DATA_W-1:0]),
    .sin   (sin),
    .cos   (cos)
  );

  assign st_next.cmd = s_tuser;
  assign st_next.sin = sin;
  assign st_next.cos = cos;
  assign st_next.x   = s_tdata[2*DATA_W-1:DATA_W];
  assign st_next.y   = s_tdata[3*DATA_W-1:2*DATA_W];

  park_rot u_rot (
    .op  (st),
    .res (out_next)
  );

  assign st_ready = !out_valid || m_tready;
  assign s_tready = !st_valid || st_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (s_tready) begin
      st_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (st_ready) begin
      out_valid <= st_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (st_ready && st_valid) begin
      out_data <= out_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_data.second, out_data.first};

  // An accepted word always lands in the operand stage
  a_fill: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> st_valid)
    else $error("accepted word did not reach the operand stage");

  // Sine and cosine are never both zero
  a_trig: assert property (@(posedge clk) disable iff (rst)
    st_valid |-> (st.sin != '0 || st.cos != '0))
    else $error("sine and cosine both zero");

  // Full pipe with a stalled output must back-pressure the input
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_tready && st_valid |-> !s_tready)
    else $error("input accepted while pipe is full");

  // A held operand moves into an empty output register
  a_drain: assert property (@(posedge clk) disable iff (rst)
    st_valid && !out_valid |=> out_valid)
    else $error("operand stage did not drain");

endmodule
